/* rtl/vic_pkg.sv */
// Shared types, codes and helpers of the virtual interrupt controller.
`default_nettype none

package vic_pkg;

	// Parameter defaults
	localparam int NUM_INTS_DEF = 64;
	localparam int NUM_CPUS_DEF = 8;

	// Fixed field widths
	localparam int MODE_W     = 3;
	localparam int IRQ_W      = 6;
	localparam int CPU_W      = 3;
	localparam int MASK_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;
	localparam int CPU_CNT_W  = 4;
	localparam int INT_CNT_W  = 7;

	// Bits examined by the scan unit per cycle
	localparam int GRP_W = 8;

	// Most CPUs a destination mask can name
	localparam int MAX_CPUS = 8;

	// Trigger mode bit value for level-triggered interrupts
	localparam logic IRQ_LEVEL = 1'b1;

	// Operation codes
	localparam logic [MODE_W-1:0] MODE_ASSERT   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DEASSERT = 3'd1;
	localparam logic [MODE_W-1:0] MODE_MASK     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_UNMASK   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SET_DEST = 3'd4;
	localparam logic [MODE_W-1:0] MODE_ACK      = 3'd5;
	localparam logic [MODE_W-1:0] MODE_EOI      = 3'd6;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CPU_COUNT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INTS_IN_USE = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [IRQ_W-1:0]  irq_number;
		logic [CPU_W-1:0]  cpu_index;
		logic [MASK_W-1:0] dest_mask;
	} item_t;

	typedef struct packed {
		logic              ack_valid;
		logic [IRQ_W-1:0]  ack_irq;
		logic [MASK_W-1:0] doorbell_flags;
		logic              irq_enabled;
		logic              irq_busy;
		logic [MASK_W-1:0] irq_dest;
		logic              error;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_DELIVER,
		ST_SCAN,
		ST_READ_P,
		ST_CHECK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic advance;
	} scan_ctl_t;

	typedef struct packed {
		logic             hit;
		logic [IRQ_W-1:0] pos;
	} scan_res_t;

	// Position of the lowest set bit of a byte
	function automatic logic [2:0] lowest8(input logic [GRP_W-1:0] v);
		logic [2:0] r;
		r = 3'd0;
		for (int b = GRP_W - 1; b >= 0; b--) begin
			if (v[b]) begin
				r = 3'(b);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/virtual_interrupt_controller_core.sv */
// Top level of the virtual interrupt controller: sequencer, state and datapath.
//
// Usage: one command word enters on item (valid/ready) and exactly one result
// word leaves on result (valid/ready). item_ready is high only while the
// sequencer is idle; the block works on one command at a time.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index at once;
// write only while the block is idle. Indexes beyond the list are dropped.
// Sequence: every command passes the read, execute and result states, and an
// assert or unmask that delivers also passes the deliver state. Acknowledge
// adds a scan step per 8-bit group stepped by the scan unit (up to NUM_INTS/8),
// a read and a check step for every pending entry examined, and a deliver step
// for every entry reissued to another CPU. The scan unit and the single read
// port of the destination RAM set this sequence.
// Reset: all flags, maps and doorbells clear at once; destination masks read
// as CPU zero through per-entry valid bits, so no clearing pass is needed.
// Stall: a result waits in the output register; the next command is accepted
// and worked up to its result stage, where it holds until the register frees.
`default_nettype none

module virtual_interrupt_controller_core #(
	parameter int NUM_INTS = vic_pkg::NUM_INTS_DEF,
	parameter int NUM_CPUS = vic_pkg::NUM_CPUS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              item_valid,
	output logic                                   item_ready,
	input  wire vic_pkg::item_t                    item,
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output vic_pkg::result_t                       result,
	input  wire logic                              cfg_wr_en,
	input  wire logic [vic_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [vic_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// Rows of per-CPU maps actually reachable: cpu count is clamped to eight
	localparam int ROWS = NUM_CPUS > vic_pkg::MAX_CPUS ? vic_pkg::MAX_CPUS : NUM_CPUS;
	localparam int RW   = ROWS > 1 ? $clog2(ROWS) : 1;
	localparam int IW   = NUM_INTS > 1 ? $clog2(NUM_INTS) : 1;

	// Sequencer
	vic_pkg::state_t state_q, state_d;

	// Configuration
	logic [vic_pkg::CFG_DATA_W-1:0] level_q;
	logic [vic_pkg::CPU_CNT_W-1:0]  cpu_cnt_q;
	logic [vic_pkg::INT_CNT_W-1:0]  ints_q;

	// Interrupt and CPU state
	logic [NUM_INTS-1:0]       asserted_q;
	logic [NUM_INTS-1:0]       enabled_q;
	logic [NUM_INTS-1:0]       dvalid_q;
	logic [NUM_INTS-1:0]       pend_q [ROWS];
	logic [NUM_INTS-1:0]       act_q  [ROWS];
	logic [vic_pkg::MASK_W-1:0] db_q;

	// Working registers of the current command
	vic_pkg::item_t             item_q;
	logic                       scan_act_q;
	logic                       from_scan_q;
	logic [vic_pkg::IRQ_W-1:0]  p_q;
	logic [vic_pkg::IRQ_W-1:0]  got_q;
	logic                       got_valid_q;
	logic                       err_q;
	logic [vic_pkg::MASK_W-1:0] dest_irq_q;
	logic                       rd_dv_q;
	vic_pkg::result_t           out_q;
	logic                       out_valid_q;

	// Decoded values
	logic [vic_pkg::CPU_CNT_W-1:0] ncpu;
	logic [vic_pkg::INT_CNT_W-1:0] nints;
	logic                          irq_ok;
	logic                          cpu_ok;
	logic [vic_pkg::MASK_W-1:0]    low_cpus;
	logic                          dest_ok;
	logic                          err_now;
	logic [IW-1:0]                 irq_idx;
	logic [IW-1:0]                 p_idx;
	logic [IW-1:0]                 dlv_idx;
	logic [NUM_INTS-1:0]           irq_bit;

	// Destination RAM
	logic                       ram_we;
	logic [IW-1:0]              ram_raddr;
	logic [vic_pkg::MASK_W-1:0] ram_rdata;
	logic [vic_pkg::MASK_W-1:0] dest_rd;
	logic [2:0]                 tgt;
	logic                       tgt_ok;

	// Row access to the per-CPU maps
	logic [RW-1:0]       row;
	logic [NUM_INTS-1:0] pend_row;
	logic [NUM_INTS-1:0] act_row;
	logic [NUM_INTS-1:0] scan_vec;

	// Scan unit
	vic_pkg::scan_ctl_t scan_ctl;
	vic_pkg::scan_res_t scan_res;

	// Control strobes
	logic sel_p;
	logic sel_tgt;
	logic out_load;
	logic chk_stale;
	logic chk_fit;
	logic busy;
	logic in_range;
	vic_pkg::result_t res_d;

	// ------------------------------------------------------------------
	// Decode
	// ------------------------------------------------------------------
	assign ncpu  = (cpu_cnt_q > vic_pkg::CPU_CNT_W'(ROWS)) ? vic_pkg::CPU_CNT_W'(ROWS) : cpu_cnt_q;
	assign nints = (ints_q > vic_pkg::INT_CNT_W'(NUM_INTS)) ? vic_pkg::INT_CNT_W'(NUM_INTS)
	                                                        : ints_q;

	assign irq_ok = vic_pkg::INT_CNT_W'(item_q.irq_number) < nints;
	assign cpu_ok = vic_pkg::CPU_CNT_W'(item_q.cpu_index) < ncpu;

	always_comb begin
		for (int b = 0; b < vic_pkg::MASK_W; b++) begin
			low_cpus[b] = vic_pkg::CPU_CNT_W'(b) < ncpu;
		end
	end

	assign dest_ok = (item_q.dest_mask != '0) && ((item_q.dest_mask & low_cpus) != '0);

	// Reject a command with a bad interrupt, CPU or destination
	always_comb begin
		case (item_q.mode) inside
			vic_pkg::MODE_ASSERT, vic_pkg::MODE_DEASSERT,
			vic_pkg::MODE_MASK, vic_pkg::MODE_UNMASK: err_now = !irq_ok;
			vic_pkg::MODE_SET_DEST:                   err_now = !irq_ok || !dest_ok;
			vic_pkg::MODE_ACK:                        err_now = !cpu_ok;
			vic_pkg::MODE_EOI:                        err_now = !irq_ok || !cpu_ok;
			default:                                  err_now = 1'b0;
		endcase
	end

	assign irq_idx = item_q.irq_number[IW-1:0];
	assign p_idx   = p_q[IW-1:0];
	assign dlv_idx = from_scan_q ? p_idx : irq_idx;
	assign irq_bit = NUM_INTS'(1) << irq_idx;

	// ------------------------------------------------------------------
	// Destination RAM: entries never written read as CPU zero
	// ------------------------------------------------------------------
	assign ram_raddr = sel_p ? p_idx : irq_idx;
	assign dest_rd   = rd_dv_q ? ram_rdata : vic_pkg::MASK_W'(1);
	assign tgt       = vic_pkg::lowest8(dest_rd);
	assign tgt_ok    = (dest_rd != '0) && (vic_pkg::CPU_CNT_W'(tgt) < ncpu);

	vic_ram #(
		.WIDTH(vic_pkg::MASK_W),
		.DEPTH(NUM_INTS)
	) u_dest_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (irq_idx),
		.wdata (item_q.dest_mask),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Map rows: the caller's row, or the delivery target's row
	// ------------------------------------------------------------------
	assign row      = sel_tgt ? RW'(tgt) : RW'(item_q.cpu_index);
	assign pend_row = pend_q[row];
	assign act_row  = act_q[row];
	assign scan_vec = scan_act_q ? act_row : pend_row;

	vic_scan #(
		.NUM_INTS(NUM_INTS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.vec    (scan_vec),
		.res    (scan_res)
	);

	assign chk_stale = !asserted_q[p_idx] || !enabled_q[p_idx];
	assign chk_fit   = dest_rd[item_q.cpu_index];

	// ------------------------------------------------------------------
	// Sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vic_pkg::ST_IDLE: begin
				if (item_valid) begin
					state_d = vic_pkg::ST_READ;
				end
			end
			vic_pkg::ST_READ: begin
				state_d = vic_pkg::ST_EXEC;
			end
			vic_pkg::ST_EXEC: begin
				state_d = vic_pkg::ST_DONE;
				if (!err_now) begin
					unique case (item_q.mode)
						vic_pkg::MODE_ASSERT: begin
							if (!asserted_q[irq_idx]) begin
								state_d = vic_pkg::ST_DELIVER;
							end
						end
						vic_pkg::MODE_UNMASK: begin
							if (asserted_q[irq_idx]) begin
								state_d = vic_pkg::ST_DELIVER;
							end
						end
						vic_pkg::MODE_ACK: begin
							state_d = vic_pkg::ST_SCAN;
						end
						default: begin
							state_d = vic_pkg::ST_DONE;
						end
					endcase
				end
			end
			vic_pkg::ST_DELIVER: begin
				state_d = from_scan_q ? vic_pkg::ST_SCAN : vic_pkg::ST_DONE;
			end
			vic_pkg::ST_SCAN: begin
				if (scan_vec == '0) begin
					state_d = vic_pkg::ST_DONE;
				end else if (scan_res.hit) begin
					state_d = scan_act_q ? vic_pkg::ST_DONE : vic_pkg::ST_READ_P;
				end
			end
			vic_pkg::ST_READ_P: begin
				state_d = vic_pkg::ST_CHECK;
			end
			vic_pkg::ST_CHECK: begin
				if (chk_stale) begin
					state_d = vic_pkg::ST_SCAN;
				end else if (chk_fit) begin
					state_d = vic_pkg::ST_DONE;
				end else begin
					state_d = vic_pkg::ST_DELIVER;
				end
			end
			vic_pkg::ST_DONE: begin
				if (!out_valid_q || result_ready) begin
					state_d = vic_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vic_pkg::ST_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: outputs
	// ------------------------------------------------------------------
	always_comb begin
		item_ready = 1'b0;
		scan_ctl   = '0;
		ram_we     = 1'b0;
		sel_p      = 1'b0;
		sel_tgt    = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			vic_pkg::ST_IDLE: begin
				item_ready = 1'b1;
			end
			vic_pkg::ST_EXEC: begin
				scan_ctl.start = (item_q.mode == vic_pkg::MODE_ACK);
				ram_we         = (item_q.mode == vic_pkg::MODE_SET_DEST) && !err_now;
			end
			vic_pkg::ST_SCAN: begin
				scan_ctl.advance = (scan_vec != '0) && !scan_res.hit;
			end
			vic_pkg::ST_READ_P, vic_pkg::ST_CHECK: begin
				// keep the entry's destination in the RAM read register
				sel_p = 1'b1;
			end
			vic_pkg::ST_DELIVER: begin
				sel_tgt = 1'b1;
			end
			vic_pkg::ST_DONE: begin
				out_load = !out_valid_q || result_ready;
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Result word
	// ------------------------------------------------------------------
	assign in_range = vic_pkg::INT_CNT_W'(item_q.irq_number) < vic_pkg::INT_CNT_W'(NUM_INTS);

	always_comb begin
		busy = asserted_q[irq_idx];
		for (int r = 0; r < ROWS; r++) begin
			busy = busy | act_q[r][irq_idx];
		end
	end

	always_comb begin
		res_d.ack_valid      = got_valid_q;
		res_d.ack_irq        = got_valid_q ? got_q : '0;
		res_d.doorbell_flags = db_q;
		res_d.irq_enabled    = in_range && enabled_q[irq_idx];
		res_d.irq_busy       = in_range && busy;
		res_d.irq_dest       = in_range ? dest_irq_q : '0;
		res_d.error          = err_q;
	end

	assign result       = out_q;
	assign result_valid = out_valid_q;

	// ------------------------------------------------------------------
	// Control state and maps
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vic_pkg::ST_IDLE;
			level_q     <= '0;
			cpu_cnt_q   <= vic_pkg::CPU_CNT_W'(1);
			ints_q      <= '0;
			asserted_q  <= '0;
			enabled_q   <= '0;
			dvalid_q    <= '0;
			db_q        <= '0;
			scan_act_q  <= 1'b0;
			from_scan_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int r = 0; r < ROWS; r++) begin
				pend_q[r] <= '0;
				act_q[r]  <= '0;
			end
		end else begin
			state_q <= state_d;

			if (cfg_wr_en) begin
				unique case (cfg_index)
					vic_pkg::CFG_LEVEL_MODE:  level_q   <= cfg_data;
					vic_pkg::CFG_CPU_COUNT:   cpu_cnt_q <= cfg_data[vic_pkg::CPU_CNT_W-1:0];
					vic_pkg::CFG_INTS_IN_USE: ints_q    <= cfg_data[vic_pkg::INT_CNT_W-1:0];
					default: begin
						// drop writes beyond the register list
						level_q <= level_q;
					end
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				vic_pkg::ST_EXEC: begin
					from_scan_q <= 1'b0;
					scan_act_q  <= act_row != '0;
					if (!err_now) begin
						unique case (item_q.mode)
							vic_pkg::MODE_DEASSERT: asserted_q[irq_idx] <= 1'b0;
							vic_pkg::MODE_MASK:     enabled_q[irq_idx]  <= 1'b0;
							vic_pkg::MODE_UNMASK:   enabled_q[irq_idx]  <= 1'b1;
							vic_pkg::MODE_SET_DEST: dvalid_q[irq_idx]   <= 1'b1;
							vic_pkg::MODE_ACK:      db_q[item_q.cpu_index] <= 1'b0;
							vic_pkg::MODE_EOI: begin
								act_q[row][irq_idx] <= 1'b0;
								// ring again if work is left once nothing is active
								if (((act_row & ~irq_bit) == '0) && (pend_row != '0)) begin
									db_q[item_q.cpu_index] <= 1'b1;
								end
							end
							default: begin
								db_q <= db_q;
							end
						endcase
					end
				end
				vic_pkg::ST_DELIVER: begin
					asserted_q[dlv_idx] <= 1'b1;
					if (tgt_ok && !pend_row[dlv_idx] && enabled_q[dlv_idx]) begin
						pend_q[row][dlv_idx] <= 1'b1;
						db_q[tgt]            <= 1'b1;
					end
				end
				vic_pkg::ST_CHECK: begin
					if (chk_stale) begin
						// drop stale or masked entry
						pend_q[row][p_idx] <= 1'b0;
					end else if (chk_fit) begin
						act_q[row][p_idx] <= 1'b1;
						if (level_q[p_q] != vic_pkg::IRQ_LEVEL) begin
							pend_q[row][p_idx] <= 1'b0;
						end
					end else begin
						// destination moved: remove here, reissue to the new CPU
						pend_q[row][p_idx] <= 1'b0;
						from_scan_q        <= 1'b1;
					end
				end
				default: begin
					scan_act_q <= scan_act_q;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		rd_dv_q <= dvalid_q[ram_raddr];

		if (item_valid && item_ready) begin
			item_q <= item;
		end

		if (state_q == vic_pkg::ST_EXEC) begin
			err_q       <= err_now;
			got_valid_q <= 1'b0;
			dest_irq_q  <= ((item_q.mode == vic_pkg::MODE_SET_DEST) && !err_now)
			               ? item_q.dest_mask : dest_rd;
		end

		if ((state_q == vic_pkg::ST_SCAN) && (scan_vec != '0) && scan_res.hit) begin
			p_q <= scan_res.pos;
			if (scan_act_q) begin
				got_q       <= scan_res.pos;
				got_valid_q <= 1'b1;
			end
		end

		if ((state_q == vic_pkg::ST_CHECK) && !chk_stale && chk_fit) begin
			got_q       <= p_q;
			got_valid_q <= 1'b1;
		end

		if (out_load) begin
			out_q <= res_d;
		end
	end

`ifndef ASSERT_OFF
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> (state_q == vic_pkg::ST_READ))
		else $error("accepted word did not start the sequencer");

	a_active_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == vic_pkg::ST_SCAN) && scan_act_q) |-> (act_row != '0))
		else $error("active scan over an empty active map");

	a_doorbell_rows: assert property (@(posedge clk) disable iff (!arst_n)
		((db_q >> ROWS) == '0))
		else $error("doorbell set for a CPU without a map row");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == vic_pkg::ST_DONE))
		else $error("result word raised outside the result stage");

	a_ack_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.ack_valid) |-> !result.error)
		else $error("acknowledge returned an interrupt on a rejected word");
`endif

endmodule

`default_nettype wire

/* rtl/vic_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module vic_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/vic_scan.sv */
// Group-at-a-time lowest-set-bit scan unit over an interrupt bitmap.
`default_nettype none

module vic_scan #(
	parameter int NUM_INTS = vic_pkg::NUM_INTS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire vic_pkg::scan_ctl_t  ctl,
	input  wire logic [NUM_INTS-1:0] vec,
	output vic_pkg::scan_res_t       res
);

	localparam int NG   = (NUM_INTS + vic_pkg::GRP_W - 1) / vic_pkg::GRP_W;
	localparam int GW   = NG > 1 ? $clog2(NG) : 1;
	localparam int PADW = NG * vic_pkg::GRP_W;

	logic [GW-1:0]               grp_q;
	logic [PADW-1:0]             vec_pad;
	logic [vic_pkg::GRP_W-1:0]   word;

	assign vec_pad = PADW'(vec);
	assign word    = vec_pad[grp_q * vic_pkg::GRP_W +: vic_pkg::GRP_W];

	assign res.hit = |word;
	assign res.pos = vic_pkg::IRQ_W'({grp_q, vic_pkg::lowest8(word)});

	// Restart at the lowest group, or advance past an empty one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= '0;
		end else if (ctl.start) begin
			grp_q <= '0;
		end else if (ctl.advance) begin
			grp_q <= grp_q + GW'(1);
		end
	end

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for virtual_interrupt_controller_core with built-in predictor.

module tb_top;
	import vic_pkg::*;

	// Mode code that the block leaves unused: no effect, no error
	localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;

	localparam int HALF_PERIOD   = 10;
	localparam int LIMIT_CYCLES  = 1000000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASES        = 6;
	localparam int WORDS_PER_PH  = 105;
	localparam int REPORT_MAX    = 10;

	// One line of the directed table: either a register write or a command word,
	// the latter optionally carrying a hand-written expected result
	typedef struct {
		bit                    is_reg;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		item_t                 cmd;
		bit                    typed;
		result_t               want;
	} step_t;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_ready;
	item_t                 cmd_word;
	logic                  result_valid;
	logic                  result_ready;
	result_t               res_word;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Travels with the command word: use a typed result instead of the predictor
	bit      word_typed;
	result_t typed_res;

	// Idling control, shared with the receiver process
	int unsigned tx_idle_pct;
	int unsigned rx_stall_pct;
	int unsigned hold_left;

	// Checking state
	result_t     outcomes_due[$];
	item_t       cmds_due[$];
	int unsigned mismatches;

	// Predictor copy of the configuration
	bit [63:0] level_cfg;
	bit [3:0]  cpu_cnt_cfg;
	bit [6:0]  int_cnt_cfg;

	// Predictor copy of the interrupt and per-CPU state
	bit [63:0] asserted_map;
	bit [63:0] enabled_map;
	bit [7:0]  dest_tab [64];
	bit [63:0] pend_map [8];
	bit [63:0] act_map [8];
	bit [7:0]  bell_map;

	// Interrupt numbers that the random part hits most often
	int unsigned hot_irq [8];

	virtual_interrupt_controller_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (cmd_word),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (res_word),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	// CPU count as the block sees it: never more than eight
	function automatic int unsigned cpus_live();
		return (cpu_cnt_cfg > 4'd8) ? 8 : int'(cpu_cnt_cfg);
	endfunction

	// Interrupts at or above this number are rejected
	function automatic int unsigned ints_live();
		return (int_cnt_cfg > 7'd64) ? 64 : int'(int_cnt_cfg);
	endfunction

	// Lowest set bit; an empty map reads as the top position
	function automatic int unsigned lowest_one(bit [63:0] v);
		int unsigned i;
		i = 0;
		while (i < 63 && !v[i]) i++;
		return i;
	endfunction

	// Mark asserted and, if enabled, make it pending on the lowest destination CPU.
	// A destination beyond the live CPU count reaches nobody.
	function automatic void post_irq(int unsigned n);
		int unsigned t;
		asserted_map[n] = 1'b1;
		if (dest_tab[n] == 8'd0) return;
		t = lowest_one({56'd0, dest_tab[n]});
		if (t >= cpus_live()) return;
		if (!pend_map[t][n] && enabled_map[n]) begin
			pend_map[t][n] = 1'b1;
			bell_map[t]    = 1'b1;
		end
	endfunction

	// Acknowledge for CPU c: lowest active first, otherwise walk the pending map.
	// Stale and masked entries drop out; entries whose destination moved are
	// reissued and leave the caller's map, so the walk always ends.
	function automatic bit claim_irq(int unsigned c, output int unsigned got);
		int unsigned p;
		got = 0;
		bell_map[c] = 1'b0;
		if (act_map[c] != 64'd0) begin
			got = lowest_one(act_map[c]);
			return 1'b1;
		end
		while (pend_map[c] != 64'd0) begin
			p = lowest_one(pend_map[c]);
			if (!asserted_map[p] || !enabled_map[p]) begin
				pend_map[c][p] = 1'b0;
			end else if (dest_tab[p][c]) begin
				act_map[c][p] = 1'b1;
				// level triggered entries stay pending until deasserted
				if (level_cfg[p] != IRQ_LEVEL) pend_map[c][p] = 1'b0;
				got = p;
				return 1'b1;
			end else begin
				pend_map[c][p] = 1'b0;
				post_irq(p);
			end
		end
		return 1'b0;
	endfunction

	// Apply one command word to the predictor state and work out its result
	function automatic result_t irq_outcome(item_t w);
		result_t     r;
		int unsigned n;
		int unsigned c;
		int unsigned got;
		bit          irq_ok;
		bit          cpu_ok;
		bit          hit;
		bit          busy;
		bit [7:0]    reach;
		n      = w.irq_number;
		c      = w.cpu_index;
		irq_ok = n < ints_live();
		cpu_ok = c < cpus_live();
		reach  = 8'((9'd1 << cpus_live()) - 9'd1);
		hit    = 1'b0;
		got    = 0;
		r      = '0;
		case (w.mode)
			MODE_ASSERT: begin
				if (!irq_ok) r.error = 1'b1;
				else if (!asserted_map[n]) post_irq(n);
			end
			MODE_DEASSERT: begin
				if (!irq_ok) r.error = 1'b1;
				else asserted_map[n] = 1'b0;
			end
			MODE_MASK: begin
				if (!irq_ok) r.error = 1'b1;
				else enabled_map[n] = 1'b0;
			end
			MODE_UNMASK: begin
				if (!irq_ok) begin
					r.error = 1'b1;
				end else begin
					enabled_map[n] = 1'b1;
					if (asserted_map[n]) post_irq(n);
				end
			end
			MODE_SET_DEST: begin
				if (!irq_ok || w.dest_mask == 8'd0 || (w.dest_mask & reach) == 8'd0)
					r.error = 1'b1;
				else
					dest_tab[n] = w.dest_mask;
			end
			MODE_ACK: begin
				if (!cpu_ok) r.error = 1'b1;
				else hit = claim_irq(c, got);
			end
			MODE_EOI: begin
				if (!irq_ok || !cpu_ok) begin
					r.error = 1'b1;
				end else begin
					act_map[c][n] = 1'b0;
					// ring again while work is left behind
					if (act_map[c] == 64'd0 && pend_map[c] != 64'd0) bell_map[c] = 1'b1;
				end
			end
			default: ;
		endcase
		busy = asserted_map[n];
		for (int k = 0; k < 8; k++) begin
			if (act_map[k][n]) busy = 1'b1;
		end
		r.ack_valid      = hit;
		r.ack_irq        = hit ? IRQ_W'(got) : '0;
		r.doorbell_flags = bell_map;
		r.irq_enabled    = enabled_map[n];
		r.irq_busy       = busy;
		r.irq_dest       = dest_tab[n];
		return r;
	endfunction

	function automatic void clear_model();
		level_cfg    = '0;
		cpu_cnt_cfg  = 4'd1;
		int_cnt_cfg  = '0;
		asserted_map = '0;
		enabled_map  = '0;
		bell_map     = '0;
		for (int i = 0; i < 64; i++) dest_tab[i] = 8'd1;
		for (int i = 0; i < 8; i++) begin
			pend_map[i] = '0;
			act_map[i]  = '0;
		end
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	function automatic step_t cmd_row(logic [MODE_W-1:0] m, int unsigned n, int unsigned c,
			logic [MASK_W-1:0] dm);
		step_t s;
		s                = '{default: '0};
		s.cmd.mode       = m;
		s.cmd.irq_number = IRQ_W'(n);
		s.cmd.cpu_index  = CPU_W'(c);
		s.cmd.dest_mask  = dm;
		return s;
	endfunction

	function automatic step_t chk_row(logic [MODE_W-1:0] m, int unsigned n, int unsigned c,
			logic [MASK_W-1:0] dm, result_t want);
		step_t s;
		s       = cmd_row(m, n, c, dm);
		s.typed = 1'b1;
		s.want  = want;
		return s;
	endfunction

	function automatic step_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		step_t s;
		s         = '{default: '0};
		s.is_reg  = 1'b1;
		s.reg_idx = idx;
		s.reg_val = v;
		return s;
	endfunction

	// Random command word, mostly well formed for the live configuration
	function automatic item_t pick_cmd();
		item_t       w;
		int unsigned r;
		int unsigned nints;
		int unsigned ncpus;
		bit [7:0]    reach;
		nints = ints_live();
		ncpus = cpus_live();
		reach = 8'((9'd1 << ncpus) - 9'd1);
		w.dest_mask = MASK_W'($urandom_range(255));
		w.cpu_index = ($urandom_range(9) == 0) ? CPU_W'($urandom_range(7))
			: CPU_W'($urandom_range(ncpus - 1));
		if (nints == 0 || $urandom_range(9) == 0)
			w.irq_number = IRQ_W'($urandom_range(63));
		else if ($urandom_range(1) == 1)
			w.irq_number = IRQ_W'(hot_irq[$urandom_range(7)]);
		else
			w.irq_number = IRQ_W'($urandom_range(nints - 1));
		r = $urandom_range(99);
		if (r < 20)      w.mode = MODE_ASSERT;
		else if (r < 30) w.mode = MODE_DEASSERT;
		else if (r < 38) w.mode = MODE_MASK;
		else if (r < 53) w.mode = MODE_UNMASK;
		else if (r < 61) w.mode = MODE_SET_DEST;
		else if (r < 83) w.mode = MODE_ACK;
		else if (r < 97) w.mode = MODE_EOI;
		else             w.mode = MODE_SPARE;
		// keep most destinations reachable so entries move between CPUs
		if (w.mode == MODE_SET_DEST && $urandom_range(3) != 0)
			w.dest_mask = w.dest_mask & reach;
		// close what the CPU really has in service, most of the time
		if (w.mode == MODE_EOI && act_map[w.cpu_index] != 64'd0 && $urandom_range(3) != 0)
			w.irq_number = IRQ_W'(lowest_one(act_map[w.cpu_index]));
		return w;
	endfunction

	// Advance to the falling edge where the next word goes out, idling on the way
	task automatic next_slot();
		int unsigned gap;
		gap = 0;
		while (gap < 30 && $urandom_range(99) < tx_idle_pct) gap++;
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Present one word and hold it until the block takes it
	task automatic offer(input item_t w, input bit typed, input result_t want);
		item_valid <= 1'b1;
		cmd_word   <= w;
		word_typed <= typed;
		typed_res  <= want;
		do @(posedge clk); while (!item_ready);
	endtask

	// Drop valid and wait until every outstanding result has come back
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (outcomes_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One-cycle register write; the predictor follows at once as the block is idle
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		case (idx)
			CFG_LEVEL_MODE:  level_cfg   = v;
			CFG_CPU_COUNT:   cpu_cnt_cfg = v[CPU_CNT_W-1:0];
			CFG_INTS_IN_USE: int_cnt_cfg = v[INT_CNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// ---------------------------------------------------------------------
	// Receiver: random stalls, plus a long hold-off on request
	// ---------------------------------------------------------------------
	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_ready <= 1'b0;
				hold_left--;
			end else begin
				result_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Scoreboard: check results in order, then predict for accepted words
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : score
		result_t e;
		item_t   ec;
		result_t p;
		bit      bad;
		if (arst_n) begin
			// check first, so a stray result can never match this edge's word
			if (result_valid && result_ready) begin
				if (outcomes_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("unexpected result word: v=%0b irq=%0d bell=%h err=%0b",
							res_word.ack_valid, res_word.ack_irq, res_word.doorbell_flags,
							res_word.error);
				end else begin
					e   = outcomes_due.pop_front();
					ec  = cmds_due.pop_front();
					bad = (res_word.ack_valid      !== e.ack_valid)
						|| (res_word.ack_irq        !== e.ack_irq)
						|| (res_word.doorbell_flags !== e.doorbell_flags)
						|| (res_word.irq_enabled    !== e.irq_enabled)
						|| (res_word.irq_busy       !== e.irq_busy)
						|| (res_word.irq_dest       !== e.irq_dest)
						|| (res_word.error          !== e.error);
					if (bad) begin
						mismatches++;
						if (mismatches <= REPORT_MAX) begin
							$display("mismatch: mode=%0d irq=%0d cpu=%0d mask=%h",
								ec.mode, ec.irq_number, ec.cpu_index, ec.dest_mask);
							$display("  exp v=%0b irq=%0d bell=%h en=%0b busy=%0b dest=%h err=%0b",
								e.ack_valid, e.ack_irq, e.doorbell_flags, e.irq_enabled,
								e.irq_busy, e.irq_dest, e.error);
							$display("  got v=%0b irq=%0d bell=%h en=%0b busy=%0b dest=%h err=%0b",
								res_word.ack_valid, res_word.ack_irq, res_word.doorbell_flags,
								res_word.irq_enabled, res_word.irq_busy, res_word.irq_dest,
								res_word.error);
						end
					end
				end
			end
			if (item_valid && item_ready) begin
				// the predictor always advances; typed rows only replace its answer
				p = irq_outcome(cmd_word);
				outcomes_due.push_back(word_typed ? typed_res : p);
				cmds_due.push_back(cmd_word);
			end
		end
	end

	// Hard stop should the block hang
	initial begin
		#(2 * HALF_PERIOD * LIMIT_CYCLES);
		$display("tb_top: errors");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin : main_seq
		step_t       plan[$];
		item_t       w;
		int unsigned nints;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		cmd_word     = '0;
		word_typed   = 1'b0;
		typed_res    = '0;
		cfg_wr_en    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_left    = 0;
		mismatches   = 0;
		clear_model();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset state: no interrupts in use, one CPU. Everything addressed is rejected
		// but acknowledge from CPU 0, which finds nothing; the spare mode is silently ignored.
		plan.push_back(reg_row(CFG_LEVEL_MODE, 64'd0));
		plan.push_back(reg_row(CFG_CPU_COUNT, 64'd1));
		plan.push_back(reg_row(CFG_INTS_IN_USE, 64'd0));
		plan.push_back(chk_row(MODE_ASSERT, 0, 0, 8'h00, '{1'b0, 6'd0, 8'h00, 1'b0, 1'b0, 8'h01, 1'b1}));
		plan.push_back(chk_row(MODE_ACK, 63, 0, 8'h00, '{1'b0, 6'd0, 8'h00, 1'b0, 1'b0, 8'h01, 1'b0}));
		plan.push_back(chk_row(MODE_ACK, 0, 7, 8'h00, '{1'b0, 6'd0, 8'h00, 1'b0, 1'b0, 8'h01, 1'b1}));
		plan.push_back(chk_row(MODE_EOI, 63, 0, 8'h00, '{1'b0, 6'd0, 8'h00, 1'b0, 1'b0, 8'h01, 1'b1}));
		plan.push_back(chk_row(MODE_SPARE, 63, 7, 8'hFF, '{1'b0, 6'd0, 8'h00, 1'b0, 1'b0, 8'h01, 1'b0}));
		// Full size, irq 1 and 63 level triggered
		plan.push_back(reg_row(CFG_INTS_IN_USE, 64'd64));
		plan.push_back(reg_row(CFG_CPU_COUNT, 64'd8));
		plan.push_back(reg_row(CFG_LEVEL_MODE, 64'h8000_0000_0000_0002));
		plan.push_back(chk_row(MODE_SET_DEST, 63, 0, 8'h80, '{1'b0, 6'd0, 8'h00, 1'b0, 1'b0, 8'h80, 1'b0}));
		plan.push_back(chk_row(MODE_SET_DEST, 0, 0, 8'h00, '{1'b0, 6'd0, 8'h00, 1'b0, 1'b0, 8'h01, 1'b1}));
		// level interrupt to the top CPU: taken, closed, doorbell rings again, then goes stale
		plan.push_back(cmd_row(MODE_UNMASK, 63, 0, 8'h00));
		plan.push_back(cmd_row(MODE_ASSERT, 63, 0, 8'h00));
		plan.push_back(cmd_row(MODE_ACK, 0, 7, 8'h00));
		plan.push_back(cmd_row(MODE_EOI, 63, 7, 8'h00));
		plan.push_back(cmd_row(MODE_DEASSERT, 63, 0, 8'h00));
		plan.push_back(cmd_row(MODE_ACK, 0, 7, 8'h00));
		// destination moved while pending: reissued to CPU 2 during the scan
		plan.push_back(cmd_row(MODE_UNMASK, 10, 0, 8'h00));
		plan.push_back(cmd_row(MODE_ASSERT, 10, 0, 8'h00));
		plan.push_back(cmd_row(MODE_SET_DEST, 10, 0, 8'h04));
		plan.push_back(cmd_row(MODE_ACK, 0, 0, 8'h00));
		plan.push_back(cmd_row(MODE_ACK, 0, 2, 8'h00));
		// masked while pending: dropped by the scan
		plan.push_back(cmd_row(MODE_UNMASK, 20, 0, 8'h00));
		plan.push_back(cmd_row(MODE_ASSERT, 20, 0, 8'h00));
		plan.push_back(cmd_row(MODE_MASK, 20, 0, 8'h00));
		plan.push_back(cmd_row(MODE_ACK, 0, 0, 8'hFF));
		// destination beyond a lowered CPU count: assert reaches nobody
		plan.push_back(cmd_row(MODE_SET_DEST, 40, 0, 8'h80));
		plan.push_back(reg_row(CFG_CPU_COUNT, 64'd2));
		plan.push_back(cmd_row(MODE_UNMASK, 40, 0, 8'h00));
		plan.push_back(cmd_row(MODE_ASSERT, 40, 0, 8'h00));
		plan.push_back(cmd_row(MODE_SET_DEST, 40, 0, 8'h80));
		plan.push_back(cmd_row(MODE_EOI, 40, 7, 8'h00));

		// Walk the table; register rows only once the block has gone quiet
		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				settle();
				put_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				next_slot();
				offer(plan[i].cmd, plan[i].typed, plan[i].want);
			end
		end

		// Random phases: each one reprogrammed, with one of four idling patterns in turn
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: put_reg(CFG_LEVEL_MODE, 64'd0);
				1: put_reg(CFG_LEVEL_MODE, '1);
				default: put_reg(CFG_LEVEL_MODE, {32'($urandom), 32'($urandom)});
			endcase
			case (ph)
				1: put_reg(CFG_CPU_COUNT, 64'd1);
				0, 5: put_reg(CFG_CPU_COUNT, 64'd8);
				default: put_reg(CFG_CPU_COUNT, 64'($urandom_range(8, 1)));
			endcase
			case (ph)
				2: put_reg(CFG_INTS_IN_USE, 64'($urandom_range(16, 1)));
				4: put_reg(CFG_INTS_IN_USE, 64'($urandom_range(64, 1)));
				default: put_reg(CFG_INTS_IN_USE, 64'd64);
			endcase
			nints = ints_live();
			foreach (hot_irq[k]) hot_irq[k] = $urandom_range(nints - 1);
			case (ph % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 62; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 62; end
				default: begin tx_idle_pct = 25; rx_stall_pct = 25; end
			endcase
			// block the output for a long stretch while words keep coming
			if (ph == 4) hold_left = 300;
			for (int k = 0; k < WORDS_PER_PH; k++) begin
				next_slot();
				w = pick_cmd();
				offer(w, 1'b0, '0);
			end
		end

		// Drain, then let the block sit a little longer for stray results
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		settle();
		if (mismatches == 0 && outcomes_due.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

/* files.f */
rtl/vic_pkg.sv
rtl/vic_ram.sv
rtl/vic_scan.sv
rtl/virtual_interrupt_controller_core.sv
verif/tb_top.sv
